// ----- rtl/core/ths_pkg.sv -----
// Shared types and constants of the tiled heightfield sampler.
// No dependencies.
package ths_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned COORD_W    = 24;
  localparam int unsigned CODE_W     = 16;
  localparam int unsigned HEIGHT_W   = 33;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHIFT_X      = 3'd0,
    CFG_SHIFT_Y      = 3'd1,
    CFG_MODE         = 3'd2,
    CFG_HEIGHT_OFS   = 3'd3,
    CFG_SCALE_SHIFT  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_HOLE    = 2'd2
  } status_e;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [CODE_W-1:0] HEIGHT_OFS_RST  = 16'd32768;
  localparam logic [3:0]        SCALE_SHIFT_RST = 4'd7;

endpackage

// ----- rtl/core/ths_in_if.sv -----
// Input channel of the sampler: post writes and sample requests.
// Depends on ths_pkg.
interface ths_in_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic                              tile_col;
  logic                              tile_row;
  logic [6:0]                        post_row;
  logic [6:0]                        post_col;
  logic [ths_pkg::CODE_W-1:0]        raw_height;
  logic                              keep;
  logic signed [ths_pkg::COORD_W-1:0] x_pos;
  logic signed [ths_pkg::COORD_W-1:0] y_pos;

  modport source (output valid, op, tile_col, tile_row, post_row, post_col, raw_height,
                  keep, x_pos, y_pos, input ready);
  modport sink (input valid, op, tile_col, tile_row, post_row, post_col, raw_height,
                keep, x_pos, y_pos, output ready);
endinterface

// ----- rtl/core/ths_out_if.sv -----
// Result channel of the sampler: status and Q16.16 height.
// Depends on ths_pkg.
interface ths_out_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic signed [ths_pkg::HEIGHT_W-1:0] height;

  modport source (output valid, status, height, input ready);
  modport sink (input valid, status, height, output ready);
endinterface

// ----- rtl/core/tiled_heightfield_sampler.sv -----
// Tiled heightfield sampler: post memory, tile lookup, 4-corner MAC, decode.
// Depends on ths_pkg, ths_in_if, ths_out_if.
// Write: the result register is set in the cycle after the word is taken. Sample steps:
// tile, address, four corner reads on the one memory read port plus one, decode.
// One word in flight: ready only in idle with the result slot free or being read.
// Reset clears tile-present bits and resets config; memory undefined until written.
module tiled_heightfield_sampler #(
  parameter int POSTS_PER_SIDE  = 65,
  parameter int TILES_X         = 2,
  parameter int TILES_Y         = 2,
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ths_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ths_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  ths_in_if.sink                           in_i,
  ths_out_if.source                        out_o
);

  localparam int F      = COORD_FRAC_BITS;
  localparam int CELLS  = POSTS_PER_SIDE - 1;
  localparam int ONE    = 1 << F;
  localparam int SPAN   = CELLS * ONE;
  localparam int TP     = POSTS_PER_SIDE * POSTS_PER_SIDE;
  localparam int NT     = TILES_X * TILES_Y;
  localparam int DEPTH  = NT * TP;
  localparam int AW     = $clog2(DEPTH);
  localparam int TW     = (NT > 1) ? $clog2(NT) : 1;
  localparam int PW     = $clog2(POSTS_PER_SIDE);
  localparam int FW     = F + 1;
  localparam int WW     = 2 * F + 1;
  localparam int NW     = 2 * F + 20;
  localparam int XW     = ths_pkg::COORD_W + 1;

  typedef enum logic [2:0] {S_IDLE, S_TILE, S_ADDR, S_RD, S_FIN} state_e;

  state_e                     state_q;
  logic                       ov_q;
  logic [1:0]                 status_q;
  logic signed [ths_pkg::HEIGHT_W-1:0] height_q;

  logic signed [XW-1:0]       shift_x_q, shift_y_q;
  logic                       mode_q;
  logic [ths_pkg::CODE_W-1:0] hofs_q;
  logic [3:0]                 hss_q;
  logic [NT-1:0]              present_q;

  logic signed [XW-1:0]       x_q, y_q;
  logic [TW-1:0]              tnum_q;
  logic [PW-1:0]              x0_q, y0_q;
  logic [FW-1:0]              tx_q, ty_q;
  logic [AW-1:0]              base_q;
  logic [WW-1:0]              w_q [4];
  logic [2:0]                 cnt_q;
  logic [3:0]                 keep_q;
  logic signed [NW-1:0]       acc_q;

  logic [16:0]                mem [DEPTH];
  logic [16:0]                rd_q;

  logic in_fire, out_fire, wr_ok;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign in_i.ready   = (state_q == S_IDLE) && (!ov_q || out_o.ready);
  assign out_o.valid  = ov_q;
  assign out_o.status = status_q;
  assign out_o.height = height_q;

  logic [TW-1:0] wtile;
  logic [AW-1:0] waddr;
  assign wr_ok = (32'(in_i.tile_col) < TILES_X) && (32'(in_i.tile_row) < TILES_Y) &&
                 (32'(in_i.post_row) < POSTS_PER_SIDE) && (32'(in_i.post_col) < POSTS_PER_SIDE);
  assign wtile = TW'(32'(in_i.tile_row) * TILES_X + 32'(in_i.tile_col));
  assign waddr = AW'(32'(wtile) * TP + 32'(in_i.post_row) * POSTS_PER_SIDE
                     + 32'(in_i.post_col));

  // tile lookup by compare against tile boundaries
  logic signed [31:0] xs, ys, cx, ry;
  int                 ti, tj;
  logic               hit;
  logic [PW-1:0]      x0, y0;
  always_comb begin
    xs = 32'(x_q);
    ys = 32'(y_q);
    ti = 0;
    tj = 0;
    for (int k = 1; k <= TILES_X; k++) if (xs >= k * SPAN) ti++;
    for (int k = 1; k <= TILES_Y; k++) if (ys >= k * SPAN) tj++;
    hit = (xs >= 0) && (xs < TILES_X * SPAN) && (ys >= 0) && (ys < TILES_Y * SPAN);
    if (hit) hit = present_q[TW'(tj * TILES_X + ti)];
    cx = xs - ti * SPAN;
    ry = (tj + 1) * SPAN - ys;
    x0 = ((cx >>> F) > CELLS - 1) ? PW'(CELLS - 1) : PW'(cx >>> F);
    y0 = ((ry >>> F) > CELLS - 1) ? PW'(CELLS - 1) : PW'(ry >>> F);
  end

  // corner weights
  logic [WW-1:0] w_d [4];
  logic [FW-1:0] itx, ity;
  always_comb begin
    itx = FW'(ONE) - tx_q;
    ity = FW'(ONE) - ty_q;
    if (!mode_q) begin
      w_d[0] = WW'(itx * ity);
      w_d[1] = WW'(tx_q * ity);
      w_d[2] = WW'(itx * ty_q);
      w_d[3] = WW'(tx_q * ty_q);
    end else if (tx_q < ty_q) begin
      w_d[0] = WW'(ity) << F;
      w_d[1] = '0;
      w_d[2] = WW'(ty_q - tx_q) << F;
      w_d[3] = WW'(tx_q) << F;
    end else begin
      w_d[0] = WW'(itx) << F;
      w_d[1] = WW'(tx_q - ty_q) << F;
      w_d[2] = '0;
      w_d[3] = WW'(ty_q) << F;
    end
  end

  logic [AW-1:0] raddr;
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    raddr = base_q;
      2'd1:    raddr = base_q + AW'(1);
      2'd2:    raddr = base_q + AW'(POSTS_PER_SIDE);
      default: raddr = base_q + AW'(POSTS_PER_SIDE + 1);
    endcase
  end

  // one corner per cycle into the accumulator
  logic signed [16:0]   cval;
  logic signed [NW-1:0] acc_d;
  logic [1:0]           ci;
  assign ci    = 2'(cnt_q - 3'd1);
  assign cval  = $signed({1'b0, rd_q[15:0]}) - $signed({1'b0, hofs_q});
  assign acc_d = acc_q + NW'($signed({1'b0, w_q[ci]}) * cval);

  logic               ok;
  int                 ksh;
  logic signed [63:0] hx;
  always_comb begin
    if (!mode_q) ok = &keep_q;
    else if (tx_q < ty_q) ok = keep_q[0] && keep_q[2] && keep_q[3];
    else ok = keep_q[0] && keep_q[1] && keep_q[3];
    ksh = 2 * F + int'(hss_q) - 16;
    hx  = 64'(acc_q);
    if (ksh <= 0) hx = hx <<< (-ksh);
    else hx = (hx + (64'sd1 <<< (ksh - 1))) >>> ksh;
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_i.op == ths_pkg::OP_WRITE && wr_ok) begin
      mem[waddr] <= {in_i.keep, in_i.raw_height};
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_x_q <= '0;
      shift_y_q <= '0;
      mode_q    <= 1'b0;
      hofs_q    <= ths_pkg::HEIGHT_OFS_RST;
      hss_q     <= ths_pkg::SCALE_SHIFT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ths_pkg::CFG_SHIFT_X:     shift_x_q <= XW'($signed(cfg_data_i));
        ths_pkg::CFG_SHIFT_Y:     shift_y_q <= XW'($signed(cfg_data_i));
        ths_pkg::CFG_MODE:        mode_q    <= cfg_data_i[0];
        ths_pkg::CFG_HEIGHT_OFS:  hofs_q    <= cfg_data_i[15:0];
        ths_pkg::CFG_SCALE_SHIFT: hss_q     <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ov_q      <= 1'b0;
      present_q <= '0;
      cnt_q     <= '0;
    end else begin
      if (out_fire) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (in_i.op == ths_pkg::OP_WRITE) begin
              if (wr_ok) present_q[wtile] <= 1'b1;
              ov_q     <= 1'b1;
              status_q <= ths_pkg::ST_OK;
              height_q <= '0;
            end else begin
              x_q     <= XW'(in_i.x_pos) + shift_x_q;
              y_q     <= XW'(in_i.y_pos) + shift_y_q;
              state_q <= S_TILE;
            end
          end
        end
        S_TILE: begin
          tnum_q <= TW'(tj * TILES_X + ti);
          x0_q   <= x0;
          y0_q   <= y0;
          tx_q   <= FW'(cx - (32'(x0) << F));
          ty_q   <= FW'(ry - (32'(y0) << F));
          if (!hit) begin
            ov_q     <= 1'b1;
            status_q <= ths_pkg::ST_MISSING;
            height_q <= '0;
            state_q  <= S_IDLE;
          end else begin
            state_q <= S_ADDR;
          end
        end
        S_ADDR: begin
          base_q  <= AW'(32'(tnum_q) * TP + 32'(y0_q) * POSTS_PER_SIDE + 32'(x0_q));
          w_q     <= w_d;
          acc_q   <= '0;
          cnt_q   <= '0;
          state_q <= S_RD;
        end
        S_RD: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q != 3'd0) begin
            acc_q      <= acc_d;
            keep_q[ci] <= rd_q[16];
          end
          if (cnt_q == 3'd4) state_q <= S_FIN;
        end
        S_FIN: begin
          ov_q     <= 1'b1;
          status_q <= ok ? ths_pkg::ST_OK : ths_pkg::ST_HOLE;
          height_q <= ok ? hx[ths_pkg::HEIGHT_W-1:0] : '0;
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_fin_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN |=> ov_q && state_q == S_IDLE)
    else $error("decode did not post a result");
  a_sample_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.op == ths_pkg::OP_SAMPLE |=> state_q == S_TILE)
    else $error("sample word did not start lookup");
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !in_i.ready)
    else $error("input taken while sample in progress");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_o.ready |=> ov_q && $stable(height_q) && $stable(status_q))
    else $error("pending result lost");

endmodule
